### sv/free_region_allocator_core_assert.svh
// Assertion macros for the free region allocator.
`ifndef FREE_REGION_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_REGION_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FRA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("free region allocator check failed");
`define FRA_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("free region allocator sequence check failed");
`else
`define FRA_ASSERT(lbl, prop)
`define FRA_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

### sv/fra_pkg.sv
// Types and constants shared by the free region allocator modules.
package fra_pkg;

  localparam int ADDR_BITS = 52;
  localparam int SIZE_BITS = 53;
  localparam int END_BITS  = 54;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_SCAN,
    S_DECIDE,
    S_APPLY
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SHRINK,
    OP_SHRINK_DROP,
    OP_GROW,
    OP_MERGE_BOTH,
    OP_PREPEND,
    OP_INSERT
  } cell_op_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_BITS-1:0] length;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] alloc_base;
    status_e              status;
  } out_beat_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } entry_t;

  typedef struct packed {
    logic [END_BITS-1:0]  need;
    logic [ADDR_BITS-1:0] addr;
    logic [END_BITS-1:0]  fin;
  } scan_t;

  typedef struct packed {
    logic fit;
    logic eqn;
    logic ovl;
    logic ge;
    logic radj;
    logic lmatch;
  } cell_flags_t;

  typedef struct packed {
    cell_op_e             op;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] delta;
  } cell_ctrl_t;

endpackage

### sv/fra_cell.sv
// One table cell: holds a region, compares it against the request, shifts with neighbors.
module fra_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic                clk,
  input  fra_pkg::scan_t      scan,
  input  fra_pkg::cell_ctrl_t ctrl,
  input  logic [IW-1:0]       pos,
  input  fra_pkg::entry_t     left_ent,
  input  fra_pkg::entry_t     right_ent,
  output fra_pkg::entry_t     ent,
  output fra_pkg::cell_flags_t flags
);

  fra_pkg::entry_t      ent_r, ent_nxt;
  fra_pkg::cell_flags_t flags_r, flags_nxt;
  logic [fra_pkg::END_BITS-1:0] rend;
  logic is_pos, after_pos;

  assign is_pos    = (pos == IW'(IDX));
  assign after_pos = (IW'(IDX) > pos);
  assign rend = fra_pkg::END_BITS'(ent_r.start) + fra_pkg::END_BITS'(ent_r.size);

  always_comb begin
    flags_nxt.fit    = fra_pkg::END_BITS'(ent_r.size) >= scan.need;
    flags_nxt.eqn    = fra_pkg::END_BITS'(ent_r.size) == scan.need;
    flags_nxt.ovl    = (fra_pkg::END_BITS'(scan.addr) < rend) &&
                       (fra_pkg::END_BITS'(ent_r.start) < scan.fin);
    flags_nxt.ge     = ent_r.start >= scan.addr;
    flags_nxt.radj   = rend == fra_pkg::END_BITS'(scan.addr);
    flags_nxt.lmatch = fra_pkg::END_BITS'(ent_r.start) == scan.fin;
  end

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      fra_pkg::OP_SHRINK: begin
        if (is_pos) begin
          ent_nxt.start = ent_r.start + ctrl.delta[fra_pkg::ADDR_BITS-1:0];
          ent_nxt.size  = ent_r.size - ctrl.delta;
        end
      end
      fra_pkg::OP_SHRINK_DROP: begin
        if (is_pos || after_pos) ent_nxt = right_ent;
      end
      fra_pkg::OP_GROW: begin
        if (is_pos) ent_nxt.size = ent_r.size + ctrl.delta;
      end
      fra_pkg::OP_MERGE_BOTH: begin
        if (is_pos) ent_nxt.size = ent_r.size + ctrl.delta + right_ent.size;
        else if (after_pos) ent_nxt = right_ent;
      end
      fra_pkg::OP_PREPEND: begin
        if (is_pos) begin
          ent_nxt.start = ctrl.addr;
          ent_nxt.size  = ent_r.size + ctrl.delta;
        end
      end
      fra_pkg::OP_INSERT: begin
        if (is_pos) begin
          ent_nxt.start = ctrl.addr;
          ent_nxt.size  = ctrl.delta;
        end else if (after_pos) begin
          ent_nxt = left_ent;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    flags_r <= flags_nxt;
  end

  assign ent   = ent_r;
  assign flags = flags_r;

endmodule

### sv/free_region_allocator_core.sv
// Free region allocator top level: sequencer, decision logic and the row of region cells.
// An input beat passes through accept, round, scan, decide and apply before its result beat is registered;
// the apply step waits while the result register is held by out_stall.
// The sequencer holds one item at a time and takes no new beat until apply is done.
// Reset (rst_n low, synchronous): table empty, page_shift 12, no result pending.
module free_region_allocator_core #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fra_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fra_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data
);

  `include "free_region_allocator_core_assert.svh"

  localparam int N  = MAX_REGIONS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int AB = fra_pkg::ADDR_BITS;
  localparam int SB = fra_pkg::SIZE_BITS;
  localparam int EB = fra_pkg::END_BITS;

  fra_pkg::state_e state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [4:0]      page_shift_r, page_shift_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [1:0]      cmd_r, cmd_nxt;
  logic [AB-1:0]   addr_r, addr_nxt;
  logic [SB-1:0]   len_r, len_nxt;
  logic [EB-1:0]   need_r, need_nxt;
  logic [EB-1:0]   fin_r, fin_nxt;
  fra_pkg::cell_ctrl_t ctrl_r, ctrl_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [AB-1:0]   base_r, base_nxt;
  fra_pkg::status_e status_r, status_nxt;
  fra_pkg::out_beat_t out_data_r, out_data_nxt;

  fra_pkg::scan_t       scan;
  fra_pkg::cell_ctrl_t  ctrl_bc;
  fra_pkg::entry_t      ent [N];
  fra_pkg::cell_flags_t flg [N];

  logic [N-1:0] valid_v, fitv, eqv, ovlv, gev, radjv, lmv;
  logic [N-1:0] ff, fg, lv, lvec;
  logic [IW-1:0] ff_idx, fg_idx, lvec_idx;
  logic [AB-1:0] ff_base;
  logic left, right, drop, full, out_free, applying;
  logic [EB-1:0] pmask;

  assign scan.need = need_r;
  assign scan.addr = addr_r;
  assign scan.fin  = fin_r;

  assign out_free = !out_valid_r || !out_stall;
  assign applying = (state_r == fra_pkg::S_APPLY) && out_free;

  always_comb begin
    ctrl_bc = ctrl_r;
    if (!applying) ctrl_bc.op = fra_pkg::OP_NOP;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    fra_pkg::entry_t le, re;
    if (g == 0) begin : g_l0
      assign le = '0;
    end else begin : g_l
      assign le = ent[g-1];
    end
    if (g == N - 1) begin : g_rn
      assign re = '0;
    end else begin : g_r
      assign re = ent[g+1];
    end
    fra_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk       (clk),
      .scan      (scan),
      .ctrl      (ctrl_bc),
      .pos       (pos_r),
      .left_ent  (le),
      .right_ent (re),
      .ent       (ent[g]),
      .flags     (flg[g])
    );
    assign valid_v[g] = CW'(g) < count_r;
    assign fitv[g]  = flg[g].fit    & valid_v[g];
    assign eqv[g]   = flg[g].eqn    & valid_v[g];
    assign ovlv[g]  = flg[g].ovl    & valid_v[g];
    assign gev[g]   = flg[g].ge     & valid_v[g];
    assign radjv[g] = flg[g].radj   & valid_v[g];
    assign lmv[g]   = flg[g].lmatch & valid_v[g];
  end

  // lowest set bit isolation (ff, fg); lv marks the highest valid cell
  assign ff = fitv & (~fitv + N'(1));
  assign fg = gev & (~gev + N'(1));
  assign lv = valid_v & ~(valid_v >> 1);
  assign lvec = (|gev) ? (fg >> 1) : lv;

  always_comb begin
    ff_idx   = '0;
    fg_idx   = '0;
    lvec_idx = '0;
    ff_base  = '0;
    for (int i = 0; i < N; i++) begin
      if (ff[i])   ff_idx   = ff_idx   | IW'(i);
      if (fg[i])   fg_idx   = fg_idx   | IW'(i);
      if (lvec[i]) lvec_idx = lvec_idx | IW'(i);
      ff_base = ff_base | ({AB{ff[i]}} & ent[i].start);
    end
  end

  assign left  = |(lvec & radjv);
  assign right = |(fg & lmv);
  assign drop  = |(ff & eqv);
  assign full  = count_r == CW'(N);
  assign pmask = (EB'(1) << page_shift_r) - EB'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    page_shift_nxt = page_shift_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    need_nxt       = need_r;
    fin_nxt        = fin_r;
    ctrl_nxt       = ctrl_r;
    pos_nxt        = pos_r;
    base_nxt       = base_r;
    status_nxt     = status_r;
    out_data_nxt   = out_data_r;
    in_stall       = state_r != fra_pkg::S_IDLE;

    if (cfg_we) page_shift_nxt = cfg_data;

    case (state_r)
      fra_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          addr_nxt  = in_data.address;
          len_nxt   = in_data.length;
          state_nxt = fra_pkg::S_CALC;
        end
      end
      fra_pkg::S_CALC: begin
        need_nxt  = (EB'(len_r) + pmask) & ~pmask;
        fin_nxt   = EB'(addr_r) + EB'(len_r);
        state_nxt = fra_pkg::S_SCAN;
      end
      fra_pkg::S_SCAN: begin
        state_nxt = fra_pkg::S_DECIDE;
      end
      fra_pkg::S_DECIDE: begin
        ctrl_nxt.op    = fra_pkg::OP_NOP;
        ctrl_nxt.addr  = addr_r;
        ctrl_nxt.delta = len_r;
        pos_nxt        = fg_idx;
        base_nxt       = '0;
        status_nxt     = fra_pkg::ST_OK;
        case (cmd_r)
          fra_pkg::CMD_ALLOC: begin
            if (|fitv) begin
              base_nxt       = ff_base;
              ctrl_nxt.delta = need_r[SB-1:0];
              ctrl_nxt.op    = drop ? fra_pkg::OP_SHRINK_DROP : fra_pkg::OP_SHRINK;
              pos_nxt        = ff_idx;
            end else begin
              status_nxt = fra_pkg::ST_NO_FIT;
            end
          end
          fra_pkg::CMD_FREE: begin
            if (len_r == '0) begin
              status_nxt = fra_pkg::ST_OK;
            end else if (fin_r > (EB'(1) << AB) || (|ovlv)) begin
              status_nxt = fra_pkg::ST_OVERLAP;
            end else if (left && right) begin
              ctrl_nxt.op = fra_pkg::OP_MERGE_BOTH;
              pos_nxt     = lvec_idx;
            end else if (left) begin
              ctrl_nxt.op = fra_pkg::OP_GROW;
              pos_nxt     = lvec_idx;
            end else if (right) begin
              ctrl_nxt.op = fra_pkg::OP_PREPEND;
              pos_nxt     = fg_idx;
            end else if (full) begin
              status_nxt = fra_pkg::ST_FULL;
            end else begin
              ctrl_nxt.op = fra_pkg::OP_INSERT;
              pos_nxt     = (|gev) ? fg_idx : count_r[IW-1:0];
            end
          end
          fra_pkg::CMD_APPEND: begin
            if (len_r == '0) begin
              status_nxt = fra_pkg::ST_OK;
            end else if (fin_r > (EB'(1) << AB)) begin
              status_nxt = fra_pkg::ST_OVERLAP;
            end else if (full) begin
              status_nxt = fra_pkg::ST_FULL;
            end else begin
              ctrl_nxt.op = fra_pkg::OP_INSERT;
              pos_nxt     = count_r[IW-1:0];
            end
          end
          default: status_nxt = fra_pkg::ST_OK;
        endcase
        state_nxt = fra_pkg::S_APPLY;
      end
      fra_pkg::S_APPLY: begin
        if (out_free) begin
          out_data_nxt.alloc_base = base_r;
          out_data_nxt.status     = status_r;
          out_valid_nxt           = 1'b1;
          case (ctrl_r.op)
            fra_pkg::OP_SHRINK_DROP,
            fra_pkg::OP_MERGE_BOTH: count_nxt = count_r - CW'(1);
            fra_pkg::OP_INSERT:     count_nxt = count_r + CW'(1);
            default:                count_nxt = count_r;
          endcase
          state_nxt = fra_pkg::S_IDLE;
        end
      end
      default: state_nxt = fra_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fra_pkg::S_IDLE;
      count_r      <= '0;
      page_shift_r <= 5'd12;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      page_shift_r <= page_shift_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    len_r      <= len_nxt;
    need_r     <= need_nxt;
    fin_r      <= fin_nxt;
    ctrl_r     <= ctrl_nxt;
    pos_r      <= pos_nxt;
    base_r     <= base_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FRA_ASSERT(a_count_bound, count_r <= CW'(N))
  `FRA_ASSERT(a_count_step, (count_r - $past(count_r) + CW'(1)) <= CW'(2))
  `FRA_ASSERT_IMPL(a_accept_calc, in_valid && !in_stall, state_r == fra_pkg::S_CALC)
  `FRA_ASSERT_IMPL(a_apply_out, applying, out_valid_r && state_r == fra_pkg::S_IDLE)

endmodule

### test/free_region_allocator_core_tb.sv
// Testbench for the free region allocator: directed and random command streams checked
// against a behavioral predictor of the region table.
module free_region_allocator_core_tb;

  localparam int NREG = 64;
  localparam int RANDOM_ITEMS = 1735;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [53:0] SPACE = 54'd1 << fra_pkg::ADDR_BITS;

  class alloc_scoreboard;
    logic [fra_pkg::ADDR_BITS-1:0] starts[NREG];
    logic [fra_pkg::SIZE_BITS-1:0] sizes[NREG];
    int count;
    logic [4:0] shift;
    fra_pkg::out_beat_t pending[$];
    int errors;

    function void clear();
      count = 0;
      shift = 5'd12;
      errors = 0;
      pending.delete();
    endfunction

    function void drop(int i);
      for (int k = i; k < count - 1; k++) begin
        starts[k] = starts[k+1];
        sizes[k] = sizes[k+1];
      end
      count--;
    endfunction

    function bit insert_at(int p, logic [fra_pkg::ADDR_BITS-1:0] b,
                           logic [fra_pkg::SIZE_BITS-1:0] s);
      if (count >= NREG) return 0;
      for (int k = count; k > p; k--) begin
        starts[k] = starts[k-1];
        sizes[k] = sizes[k-1];
      end
      starts[p] = b;
      sizes[p] = s;
      count++;
      return 1;
    endfunction

    function fra_pkg::status_e put_back(logic [fra_pkg::ADDR_BITS-1:0] a,
                                        logic [fra_pkg::SIZE_BITS-1:0] l);
      logic [63:0] fin, rend;
      int p;
      bit lm, rm;
      fin = 64'(a) + 64'(l);
      if (l == 0) return fra_pkg::ST_OK;
      if (fin > 64'(SPACE)) return fra_pkg::ST_OVERLAP;
      for (int i = 0; i < count; i++) begin
        rend = 64'(starts[i]) + 64'(sizes[i]);
        if (64'(a) < rend && 64'(starts[i]) < fin) return fra_pkg::ST_OVERLAP;
      end
      p = count;
      for (int i = 0; i < count; i++)
        if (starts[i] >= a) begin
          p = i;
          break;
        end
      lm = p > 0 && 64'(starts[p-1]) + 64'(sizes[p-1]) == 64'(a);
      rm = p < count && 64'(starts[p]) == fin;
      if (lm && rm) begin
        sizes[p-1] = sizes[p-1] + l + sizes[p];
        drop(p);
      end else if (lm) begin
        sizes[p-1] = sizes[p-1] + l;
      end else if (rm) begin
        starts[p] = a;
        sizes[p] = sizes[p] + l;
      end else if (!insert_at(p, a, l)) begin
        return fra_pkg::ST_FULL;
      end
      return fra_pkg::ST_OK;
    endfunction

    function void note_input(fra_pkg::in_beat_t b);
      fra_pkg::out_beat_t r;
      logic [63:0] page, need;
      r.alloc_base = '0;
      r.status = fra_pkg::ST_OK;
      case (fra_pkg::cmd_e'(b.cmd))
        fra_pkg::CMD_ALLOC: begin
          page = 64'd1 << shift;
          need = (64'(b.length) + page - 64'd1) & ~(page - 64'd1);
          r.status = fra_pkg::ST_NO_FIT;
          for (int i = 0; i < count; i++)
            if (64'(sizes[i]) >= need) begin
              r.alloc_base = starts[i];
              r.status = fra_pkg::ST_OK;
              starts[i] = starts[i] + need[fra_pkg::ADDR_BITS-1:0];
              sizes[i] = sizes[i] - need[fra_pkg::SIZE_BITS-1:0];
              if (sizes[i] == 0) drop(i);
              break;
            end
        end
        fra_pkg::CMD_FREE: r.status = put_back(b.address, b.length);
        fra_pkg::CMD_APPEND: begin
          if (b.length == 0) r.status = fra_pkg::ST_OK;
          else if (64'(b.address) + 64'(b.length) > 64'(SPACE))
            r.status = fra_pkg::ST_OVERLAP;
          else if (!insert_at(count, b.address, b.length)) r.status = fra_pkg::ST_FULL;
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(fra_pkg::out_beat_t got);
      fra_pkg::out_beat_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.alloc_base !== e.alloc_base) begin
        $error("alloc_base expected %h actual %h", e.alloc_base, got.alloc_base);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  fra_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  fra_pkg::out_beat_t out_data;
  logic cfg_we = 0;
  logic [4:0] cfg_data = '0;

  alloc_scoreboard sb;
  int idle_cycles = 0;
  int hold_request = 0;
  int results_seen = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  free_region_allocator_core #(.MAX_REGIONS(NREG)) dut (.*);

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen++;
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall per beat, plus long hold-offs on request
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request > 0) begin
        out_stall <= 1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 9) < 3) w = 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  // valid stays up after a beat unless a gap follows; drain() drops it
  task automatic send(fra_pkg::in_beat_t b, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk iff !in_stall);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_shift(logic [4:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.shift = v;
  endtask

  function automatic fra_pkg::in_beat_t beat(fra_pkg::cmd_e c,
                                             logic [fra_pkg::ADDR_BITS-1:0] a,
                                             logic [fra_pkg::SIZE_BITS-1:0] l);
    fra_pkg::in_beat_t b;
    b.cmd = c;
    b.address = a;
    b.length = l;
    return b;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic fra_pkg::in_beat_t random_beat();
    logic [fra_pkg::ADDR_BITS-1:0] a;
    logic [fra_pkg::SIZE_BITS-1:0] l;
    int k;
    k = $urandom_range(0, 99);
    a = fra_pkg::ADDR_BITS'(($urandom_range(0, 4095) << 12) +
        ($urandom_range(0, 7) == 0 ? $urandom_range(0, 4095) : 0));
    l = fra_pkg::SIZE_BITS'($urandom_range(1, 24) << 12);
    if ($urandom_range(0, 9) == 0) l = fra_pkg::SIZE_BITS'($urandom_range(0, 'h3000));
    if ($urandom_range(0, 29) == 0) begin
      a = fra_pkg::ADDR_BITS'(rand64());
      l = fra_pkg::SIZE_BITS'(rand64());
    end
    if (k < 40) return beat(fra_pkg::CMD_ALLOC, fra_pkg::ADDR_BITS'(rand64()), l);
    if (k < 85) return beat(fra_pkg::CMD_FREE, a, l);
    if (k < 95) return beat(fra_pkg::CMD_APPEND, a, l);
    return beat(fra_pkg::CMD_NONE, fra_pkg::ADDR_BITS'(rand64()),
                fra_pkg::SIZE_BITS'(rand64()));
  endfunction

  initial begin
    sb = new();
    sb.clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd100), 0);
    send(beat(fra_pkg::CMD_NONE, '1, '1), 0);
    send(beat(fra_pkg::CMD_APPEND, 52'h1000, 53'h4000), 0);
    send(beat(fra_pkg::CMD_APPEND, 52'h10000, '0), 0);
    send(beat(fra_pkg::CMD_APPEND, '1, 53'd2), 0);
    send(beat(fra_pkg::CMD_APPEND, 52'h20000, 53'h8000), 0);
    send(beat(fra_pkg::CMD_ALLOC, '1, '0), 0);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd1), 0);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'h3000), 0);
    send(beat(fra_pkg::CMD_ALLOC, '0, '1), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h1000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h1000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h28000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h1e000, 53'h2000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h30000, '0), 0);
    send(beat(fra_pkg::CMD_FREE, '1, 53'd2), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h40000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h3f000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, '0, 53'h1000_0000_0000_0), 0);
    send(beat(fra_pkg::CMD_APPEND, '0, 53'h1000_0000_0000_0), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h3c000, 53'h2000), 0);
    send(beat(fra_pkg::CMD_APPEND, 52'h5000, 53'h1000), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h4000, 53'h100), 0);

    // fill the table to the limit
    for (int i = 0; i < NREG + 2; i++)
      send(beat(fra_pkg::CMD_FREE, 52'h1000000 + 52'(i) * 52'h2000, 53'h1000),
           $urandom_range(0, 1));
    send(beat(fra_pkg::CMD_FREE, 52'h1001000, 53'h1000), 0);
    set_shift(5'd0);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd7), 0);
    set_shift(5'd31);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd1), 0);
    send(beat(fra_pkg::CMD_FREE, 52'h8000_0000, 53'h8000_0000), 0);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd1), 0);
    set_shift(5'd30);
    send(beat(fra_pkg::CMD_ALLOC, '0, 53'd1), 0);
    set_shift(5'd12);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) begin
        hold_request = 200;
        for (int j = 0; j < 20; j++) send(random_beat(), 0);
      end
      if (i % 400 == 399) drain();
      if (i == 600) set_shift(5'd0);
      if (i == 900) set_shift(5'd16);
      if (i == 1200) set_shift(5'd30);
      if (i == 1400) set_shift(5'd12);
      send(random_beat(), 1);
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Covered directed edge cases, a full table, page shifts 0, 12, 16, 30, 31");
    $display("and a long output hold-off; %0d result beats checked.", results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
